/* src/ssba_pkg.sv */
// Shared types and constants of the swap slot bitmap allocator.
`timescale 1ns / 1ps

package ssba_pkg;

   // Field widths of the request, result and register ports.
   localparam int CMD_W    = 2;
   localparam int SLOT_W   = 10;
   localparam int SECTOR_W = 13;
   localparam int STATUS_W = 2;
   localparam int CSR_W    = 11;

   // The free bitmap is stored as rows of this many slots.
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   localparam logic [CMD_W-1:0] CMD_SWAP_OUT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWAP_IN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_XFER  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd2;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_READ,
      OP_RELEASE
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic              can_free;
   } cmd_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN,
      BK_FREE,
      BK_PREP,
      BK_EMIT,
      BK_SINGLE
   } back_state_type;

endpackage

/* src/ssba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ssba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ssba_front.sv */
// Front end: accepts requests, decodes the command and pushes work into the queue.
`timescale 1ns / 1ps

module ssba_front
   import ssba_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [SLOT_W-1:0]   req_slot_index,
   input  q_status_type        q_status,
   input  logic                clearing,
   output logic                push,
   output cmd_entry_type       push_entry
);

   localparam int CMP_W = 18;
   localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_SLOTS);

   logic accept;
   logic known;

   // Nothing is taken while the bitmap is being initialized.
   assign req_stall = q_status.full || clearing;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      known           = 1'b1;
      push_entry.op   = OP_ALLOC;
      push_entry.slot = req_slot_index;
      // Slots beyond the bitmap still transfer but never touch a free bit.
      push_entry.can_free = (CMP_W'(req_slot_index) < MAX_C);
      case (req_command)
         CMD_SWAP_OUT: push_entry.op = OP_ALLOC;
         CMD_SWAP_IN:  push_entry.op = OP_READ;
         CMD_RELEASE:  push_entry.op = OP_RELEASE;
         default:      known = 1'b0;
      endcase
   end

   // An unknown command is accepted and dropped here.
   assign push = accept && known && !reset;

endmodule

/* src/ssba_queue.sv */
// Two-entry queue of decoded commands between the front end and the back end.
`timescale 1ns / 1ps

module ssba_queue
   import ssba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_entry_type push_entry,
   input  logic          pop,
   output cmd_entry_type head,
   output q_status_type  q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   cmd_entry_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);

endmodule

/* src/ssba_back.sv */
// Back end: bitmap clearing, first-fit scan, slot freeing and result sequencing.
`timescale 1ns / 1ps

module ssba_back
   import ssba_pkg::*;
#(
   parameter int MAX_SLOTS        = 1024,
   parameter int SECTORS_PER_SLOT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [CSR_W-1:0]    slots_in_use,
   input  cmd_entry_type       head,
   input  q_status_type        q_status,
   output logic                pop,
   output logic                clearing,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SECTOR_W-1:0] rsp_sector_number,
   output logic                rsp_is_read,
   output logic [SLOT_W-1:0]   rsp_slot_used,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam int IDX_W = ($clog2(MAX_SLOTS) > SLOT_W) ? $clog2(MAX_SLOTS) : SLOT_W;
   localparam int ROWS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CMP_W = ((ROW_W + BIT_W > CSR_W) ? ROW_W + BIT_W : CSR_W) + 1;
   localparam int K_W   = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
   localparam int MUL_W = IDX_W + 7;
   localparam logic [CMP_W-1:0] MAX_C    = CMP_W'(MAX_SLOTS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [K_W-1:0]   LAST_K   = K_W'(SECTORS_PER_SLOT - 1);
   localparam logic [MUL_W-1:0] SPS_MUL  = MUL_W'(SECTORS_PER_SLOT);

   // Bits of a row that belong to slots below the given limit.
   function automatic logic [WORD_W-1:0] row_mask(input logic [ROW_W-1:0] row,
                                                  input logic [CMP_W-1:0] lim);
      logic [CMP_W-1:0]  lo;
      logic [CMP_W-1:0]  hi;
      logic [WORD_W-1:0] m;
      lo = CMP_W'({row, {BIT_W{1'b0}}});
      hi = lo + CMP_W'(WORD_W);
      if (hi <= lim) begin
         m = '1;
      end else if (lo >= lim) begin
         m = '0;
      end else begin
         m = ~({WORD_W{1'b1}} << lim[BIT_W-1:0]);
      end
      return m;
   endfunction

   back_state_type state_ff, state_in;

   logic [ROW_W-1:0]    clr_row_ff, clr_row_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [ROW_W-1:0]    hint_ff, hint_in;
   op_type              op_ff, op_in;
   logic [IDX_W-1:0]    slot_ff, slot_in;
   logic [CMP_W-1:0]    limit_ff, limit_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic [K_W-1:0]      cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SECTOR_W-1:0] rsp_sector_ff, rsp_sector_in;
   logic                rsp_is_read_ff, rsp_is_read_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                ram_wr_en;
   logic [ROW_W-1:0]    ram_wr_addr;
   logic [WORD_W-1:0]   ram_wr_data;
   logic                ram_rd_en;
   logic [ROW_W-1:0]    ram_rd_addr;
   logic [WORD_W-1:0]   ram_rd_data;

   logic [CMP_W-1:0]    lim_now;
   logic [CMP_W-1:0]    csr_ext;
   logic [WORD_W-1:0]   scan_hits;
   logic [BIT_W-1:0]    hit_bit;
   logic [CMP_W-1:0]    scan_hi;
   logic                end_reached;
   logic [IDX_W-1:0]    head_slot_ext;
   logic [ROW_W-1:0]    head_row;
   logic [ROW_W-1:0]    slot_row;
   logic [BIT_W-1:0]    slot_bit;
   logic [MUL_W-1:0]    base_prod;
   logic                out_free;

   ssba_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ROWS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign csr_ext       = CMP_W'(slots_in_use);
   assign lim_now       = (csr_ext > MAX_C) ? MAX_C : csr_ext;
   assign scan_hits     = ram_rd_data & row_mask(row_ff, limit_ff);
   assign scan_hi       = CMP_W'({row_ff, {BIT_W{1'b0}}}) + CMP_W'(WORD_W);
   assign end_reached   = (scan_hi >= limit_ff) || (row_ff == LAST_ROW);
   assign head_slot_ext = IDX_W'(head.slot);
   assign head_row      = head_slot_ext[BIT_W +: ROW_W];
   assign slot_row      = slot_ff[BIT_W +: ROW_W];
   assign slot_bit      = slot_ff[BIT_W-1:0];
   assign base_prod     = MUL_W'(slot_ff) * SPS_MUL;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign clearing      = (state_ff == BK_CLEAR);

   always_comb begin
      hit_bit = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (scan_hits[i]) begin
            hit_bit = BIT_W'(i);
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_row_ff == LAST_ROW) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               case (head.op)
                  OP_ALLOC:   state_in = BK_SCAN;
                  OP_READ:    state_in = head.can_free ? BK_FREE : BK_PREP;
                  OP_RELEASE: state_in = head.can_free ? BK_FREE : BK_SINGLE;
                  default:    state_in = BK_IDLE;
               endcase
            end
         end
         BK_SCAN: begin
            if (scan_hits != '0) begin
               state_in = BK_PREP;
            end else if (end_reached) begin
               state_in = BK_SINGLE;
            end
         end
         BK_FREE: begin
            state_in = (op_ff == OP_READ) ? BK_PREP : BK_SINGLE;
         end
         BK_PREP: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free && cnt_ff == LAST_K) begin
               state_in = BK_IDLE;
            end
         end
         BK_SINGLE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_CLEAR;
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      pop            = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = row_ff;
      ram_wr_data    = ram_rd_data;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = row_ff;
      clr_row_in     = clr_row_ff;
      row_in         = row_ff;
      hint_in        = hint_ff;
      op_in          = op_ff;
      slot_in        = slot_ff;
      limit_in       = limit_ff;
      sector_in      = sector_ff;
      cnt_in         = cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_sector_in  = rsp_sector_ff;
      rsp_is_read_in = rsp_is_read_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      case (state_ff)
         BK_CLEAR: begin
            // Slots past the end of the bitmap are stored as taken.
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_row_ff;
            ram_wr_data = row_mask(clr_row_ff, MAX_C);
            clr_row_in  = clr_row_ff + 1'b1;
            hint_in     = '0;
         end
         BK_IDLE: begin
            if (!q_status.empty) begin
               pop       = 1'b1;
               op_in     = head.op;
               slot_in   = head_slot_ext;
               limit_in  = lim_now;
               ram_rd_en = 1'b1;
               if (head.op == OP_ALLOC) begin
                  ram_rd_addr = hint_ff;
                  row_in      = hint_ff;
               end else begin
                  ram_rd_addr = head_row;
                  row_in      = head_row;
               end
            end
         end
         BK_SCAN: begin
            // Every row below the hint has no free slot at all.
            if (ram_rd_data == '0 && row_ff == hint_ff && row_ff != LAST_ROW) begin
               hint_in = row_ff + 1'b1;
            end
            if (scan_hits != '0) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = row_ff;
               ram_wr_data = ram_rd_data & ~(WORD_W'(1) << hit_bit);
               slot_in     = IDX_W'({row_ff, hit_bit});
            end else if (end_reached) begin
               slot_in = '0;
            end else begin
               row_in      = row_ff + 1'b1;
               ram_rd_en   = 1'b1;
               ram_rd_addr = row_ff + 1'b1;
            end
         end
         BK_FREE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = slot_row;
            ram_wr_data = ram_rd_data | (WORD_W'(1) << slot_bit);
            if (slot_row < hint_ff) begin
               hint_in = slot_row;
            end
         end
         BK_PREP: begin
            sector_in = base_prod[SECTOR_W-1:0];
            cnt_in    = '0;
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sector_in  = sector_ff;
               rsp_is_read_in = (op_ff == OP_READ);
               rsp_slot_in    = slot_ff[SLOT_W-1:0];
               rsp_status_in  = STATUS_XFER;
               rsp_last_in    = (cnt_ff == LAST_K);
               sector_in      = sector_ff + 1'b1;
               cnt_in         = cnt_ff + 1'b1;
            end
         end
         BK_SINGLE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_sector_in  = '0;
               rsp_is_read_in = 1'b0;
               rsp_slot_in    = slot_ff[SLOT_W-1:0];
               rsp_status_in  = (op_ff == OP_ALLOC) ? STATUS_FULL : STATUS_FREED;
               rsp_last_in    = 1'b1;
            end
         end
         default: begin
            clr_row_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_row_ff   <= '0;
         hint_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_row_ff   <= clr_row_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff         <= row_in;
      op_ff          <= op_in;
      slot_ff        <= slot_in;
      limit_ff       <= limit_in;
      sector_ff      <= sector_in;
      cnt_ff         <= cnt_in;
      rsp_sector_ff  <= rsp_sector_in;
      rsp_is_read_ff <= rsp_is_read_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sector_number = rsp_sector_ff;
   assign rsp_is_read       = rsp_is_read_ff;
   assign rsp_slot_used     = rsp_slot_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

/* src/swap_slot_bitmap_allocator_top.sv */
// Top level of the first-fit swap slot bitmap allocator.
// Requests enter on req_ (valid/stall) with a command and a slot index; each request
// transaction yields result transactions on rsp_ (valid/stall), the final one with
// rsp_last set. Swap-out claims the lowest free slot below the slot count and gives
// SECTORS_PER_SLOT write sectors, or one "no free slot" result. Swap-in gives the
// slot's read sectors and frees it; release frees it and gives one result.
// The slot count is written on csr_ (valid/ready, always ready); the user writes it
// only while idle, which the block does not enforce. A decoded request waits in a
// two-entry queue, so req_ keeps accepting while the back end works or rsp_ is
// stalled; when rsp_ stalls, the back end holds its result and stops, and req_stall
// rises once the queue is full. In the back end, swap-in reads the slot's bitmap row,
// writes it back with the slot's bit set, prepares the first sector and emits
// SECTORS_PER_SLOT results; release reads and writes the row the same way and emits
// one result. Swap-out scans the 32-slot bitmap rows, one row per cycle, starting at
// the lowest row that may hold a free slot, clears the first free bit it finds, then
// prepares and emits its sectors; a full device ends the scan with one result. The
// bitmap RAM has one port of each kind. After reset the back end marks every slot
// below MAX_SLOTS free in the bitmap, one row per cycle, while req_stall stays high.
`timescale 1ns / 1ps

module swap_slot_bitmap_allocator_top
   import ssba_pkg::*;
#(
   parameter int MAX_SLOTS        = 1024,
   parameter int SECTORS_PER_SLOT = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [SLOT_W-1:0]   req_slot_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SECTOR_W-1:0] rsp_sector_number,
   output logic                rsp_is_read,
   output logic [SLOT_W-1:0]   rsp_slot_used,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CSR_W-1:0]    csr_slots_in_use
);

   logic [CSR_W-1:0] slots_ff, slots_in;
   logic             push;
   logic             pop;
   logic             clearing;
   cmd_entry_type    push_entry;
   cmd_entry_type    head;
   q_status_type     q_status;

   assign csr_ready = 1'b1;
   assign slots_in  = (csr_valid && csr_ready) ? csr_slots_in_use : slots_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= CSR_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   ssba_front #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_front (
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_slot_index (req_slot_index),
      .q_status       (q_status),
      .clearing       (clearing),
      .push           (push),
      .push_entry     (push_entry)
   );

   ssba_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   ssba_back #(
      .MAX_SLOTS        (MAX_SLOTS),
      .SECTORS_PER_SLOT (SECTORS_PER_SLOT)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .slots_in_use      (slots_ff),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_sector_number (rsp_sector_number),
      .rsp_is_read       (rsp_is_read),
      .rsp_slot_used     (rsp_slot_used),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // The back end never takes an entry from an empty queue.
   assert property (@(posedge clock) disable iff (reset) pop |-> !q_status.empty)
      else $error("queue popped while empty");

   // No request is taken while the bitmap is being initialized.
   assert property (@(posedge clock) disable iff (reset) clearing |-> req_stall)
      else $error("request accepted during bitmap clear");

   // A full device gives a single result with zeroed transfer fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (rsp_last && rsp_sector_number == '0 && !rsp_is_read && rsp_slot_used == '0))
      else $error("malformed no-free-slot result");

   // Every result without a transfer closes its request.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_XFER) |-> rsp_last)
      else $error("non-transfer result without last");

endmodule
